// File: src/csd_pkg.sv
package csd_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ON_THRESHOLD     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_THRESHOLD    = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_CLAP_TICKS   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CLAP_TICKS   = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FLASH_LEVEL      = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FLASH_TICKS      = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_TICKS       = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_NOISE_OFF_ENABLE = 4'd7;

  localparam logic [10:0] ON_THRESHOLD_RESET   = 11'd150;
  localparam logic [10:0] OFF_THRESHOLD_RESET  = 11'd900;
  localparam logic [6:0]  MIN_CLAP_RESET       = 7'd4;
  localparam logic [9:0]  MAX_CLAP_RESET       = 10'd150;
  localparam logic [9:0]  FLASH_LEVEL_RESET    = 10'd1023;
  localparam logic [9:0]  FLASH_TICKS_RESET    = 10'd100;
  localparam logic [31:0] IDLE_TICKS_RESET     = 32'd3600000;

  localparam logic [9:0]  LEVEL_MAX    = 10'd1023;
  localparam logic [10:0] THRESH_RESET = 11'd600;
  localparam logic [2:0]  SHIFT_TOP    = 3'd6;

  typedef enum logic [3:0] {
    LS_OFF       = 4'd0,
    LS_OFF_NOISE = 4'd1,
    LS_OFF_WAIT  = 4'd2,
    LS_FLASH     = 4'd3,
    LS_RAMP_UP   = 4'd4,
    LS_ON        = 4'd5,
    LS_ON_NOISE  = 4'd6,
    LS_ON_WAIT   = 4'd7,
    LS_RAMP_DOWN = 4'd8
  } light_state_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_SCAN,
    SQ_UPDATE,
    SQ_SQUARE,
    SQ_EMIT
  } seq_state_t;

  typedef struct packed {
    logic signed [9:0] audio_sample;
    logic [9:0]        pot_level;
    logic              pot_moved;
  } in_word_t;

  typedef struct packed {
    logic [9:0]   light_level;
    logic [2:0]   prescale_shift;
    logic [7:0]   duty;
    logic         clap_detected;
    light_state_t light_state;
  } out_word_t;

  typedef struct packed {
    logic [10:0] on_threshold;
    logic [10:0] off_threshold;
    logic [6:0]  min_clap_ticks;
    logic [9:0]  max_clap_ticks;
    logic [9:0]  flash_level;
    logic [9:0]  flash_ticks;
    logic [31:0] idle_ticks;
    logic        noise_off_enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
    logic square;
    logic emit;
  } seq_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } seq_status_t;

  typedef struct packed {
    logic [9:0]   level;
    light_state_t state;
    logic         clap;
  } light_view_t;

endpackage

// File: src/csd_seq.sv
module csd_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  csd_pkg::seq_status_t status,
  output csd_pkg::seq_cmd_t    cmd
);
  import csd_pkg::*;

  seq_state_t state;
  seq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SQ_IDLE: begin
        if (in_valid) state_next = SQ_SCAN;
      end
      SQ_SCAN: begin
        if (status.scan_last) state_next = SQ_UPDATE;
      end
      SQ_UPDATE: state_next = SQ_SQUARE;
      SQ_SQUARE: state_next = SQ_EMIT;
      SQ_EMIT: begin
        if (!status.out_busy) state_next = SQ_IDLE;
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      SQ_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      SQ_SCAN:   cmd.scan = 1'b1;
      SQ_UPDATE: cmd.update = 1'b1;
      SQ_SQUARE: cmd.square = 1'b1;
      SQ_EMIT:   cmd.emit = !status.out_busy;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: src/csd_window.sv
module csd_window #(
  parameter int WINDOW_LENGTH = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              scan,
  input  logic signed [9:0] sample,
  output logic              scan_last,
  output logic [10:0]       amp
);
  import csd_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_LENGTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW_LENGTH - 1);

  logic signed [9:0]  ring [WINDOW_LENGTH];
  logic [IDX_W-1:0]   pos;
  logic [IDX_W-1:0]   idx;
  logic signed [9:0]  hi;
  logic signed [9:0]  lo;
  logic signed [9:0]  rd;
  logic signed [10:0] diff;

  assign rd        = ring[idx];
  assign scan_last = (idx == LAST);
  assign diff      = {hi[9], hi} - {lo[9], lo};
  assign amp       = diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) ring[i] <= '0;
      pos <= '0;
    end else if (load) begin
      ring[pos] <= sample;
      pos <= (pos == LAST) ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= '0;
    end else if (scan) begin
      idx <= scan_last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (scan) begin
      if (idx == '0) begin
        hi <= rd;
        lo <= rd;
      end else begin
        if (rd > hi) hi <= rd;
        if (rd < lo) lo <= rd;
      end
    end
  end

endmodule

// File: src/csd_light.sv
module csd_light #(
  parameter int RAMP_STEP = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 update,
  input  logic [9:0]           pot_level,
  input  logic                 pot_moved,
  input  logic [10:0]          amp,
  input  csd_pkg::cfg_t        cfg,
  output csd_pkg::light_view_t view
);
  import csd_pkg::*;

  localparam logic [9:0] STEP = 10'(RAMP_STEP);

  logic [9:0]   pot;
  logic         moved;
  light_state_t state;
  light_state_t state_next;
  logic [9:0]   level;
  logic [9:0]   level_next;
  logic [15:0]  short_count;
  logic [31:0]  long_count;
  logic [10:0]  thresh;
  logic [10:0]  thresh_next;
  logic         clap;
  logic         clap_now;
  logic         short_clear;
  logic         long_clear;
  logic [10:0]  ramp_sum;

  assign clap_now = amp > thresh;
  assign ramp_sum = {1'b0, level} + {1'b0, STEP};

  always_comb begin
    state_next  = state;
    level_next  = level;
    thresh_next = cfg.on_threshold;
    short_clear = 1'b0;
    long_clear  = 1'b0;
    case (state)
      LS_OFF: begin
        if (moved) begin
          state_next = LS_RAMP_UP;
        end else if (clap_now) begin
          short_clear = 1'b1;
          state_next  = LS_OFF_NOISE;
        end
      end
      LS_OFF_NOISE: begin
        if (moved) begin
          state_next = LS_RAMP_UP;
        end else if (!clap_now && short_count < {9'd0, cfg.min_clap_ticks}) begin
          state_next = LS_OFF;
        end else if (!clap_now && short_count <= {6'd0, cfg.max_clap_ticks}) begin
          level_next = cfg.flash_level;
          state_next = LS_FLASH;
        end else if (short_count > {6'd0, cfg.max_clap_ticks}) begin
          state_next = LS_OFF_WAIT;
        end
      end
      LS_OFF_WAIT: begin
        if (moved) begin
          state_next = LS_RAMP_UP;
        end else if (!clap_now) begin
          state_next = LS_OFF;
        end
      end
      LS_FLASH: begin
        if (moved) begin
          state_next = LS_RAMP_UP;
        end else if (short_count >= {6'd0, cfg.flash_ticks}) begin
          level_next = '0;
          state_next = LS_RAMP_UP;
        end
      end
      LS_RAMP_UP: begin
        thresh_next = cfg.off_threshold;
        if (pot == '0) begin
          level_next = '0;
          state_next = LS_OFF;
        end else if (clap_now) begin
          level_next  = pot;
          short_clear = 1'b1;
          long_clear  = 1'b1;
          state_next  = LS_ON_NOISE;
        end else if (level >= pot) begin
          level_next = pot;
          long_clear = 1'b1;
          state_next = LS_ON;
        end else if (ramp_sum > {1'b0, LEVEL_MAX}) begin
          level_next = LEVEL_MAX;
        end else begin
          level_next = ramp_sum[9:0];
        end
      end
      LS_ON: begin
        thresh_next = cfg.off_threshold;
        if (moved) begin
          level_next = pot;
        end else if (long_count >= cfg.idle_ticks) begin
          state_next = LS_RAMP_DOWN;
        end else if (clap_now && cfg.noise_off_enable) begin
          short_clear = 1'b1;
          state_next  = LS_ON_NOISE;
        end else begin
          level_next = pot;
        end
      end
      LS_ON_NOISE: begin
        thresh_next = cfg.off_threshold;
        level_next  = pot;
        if (moved) begin
          state_next = LS_ON;
        end else if (!clap_now && short_count < {9'd0, cfg.min_clap_ticks}) begin
          state_next = LS_ON;
        end else if (!clap_now && short_count <= {6'd0, cfg.max_clap_ticks}) begin
          state_next = LS_RAMP_DOWN;
        end else if (short_count > {6'd0, cfg.max_clap_ticks}) begin
          state_next = LS_ON_WAIT;
        end
      end
      LS_ON_WAIT: begin
        thresh_next = cfg.off_threshold;
        level_next  = pot;
        if (!clap_now) state_next = LS_ON;
      end
      LS_RAMP_DOWN: begin
        if (moved) begin
          state_next = LS_RAMP_UP;
        end else if (level == '0) begin
          state_next = LS_OFF;
        end else if (level > STEP) begin
          level_next = level - STEP;
        end else begin
          level_next = '0;
        end
      end
      default: begin
        state_next = LS_OFF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pot   <= pot_level;
      moved <= pot_moved;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= LS_OFF;
      level       <= '0;
      short_count <= '0;
      long_count  <= '0;
      thresh      <= THRESH_RESET;
      clap        <= 1'b0;
    end else if (update) begin
      state       <= state_next;
      level       <= level_next;
      short_count <= (short_clear ? 16'd0 : short_count) + 16'd1;
      long_count  <= (long_clear ? 32'd0 : long_count) + 32'd1;
      thresh      <= thresh_next;
      clap        <= clap_now;
    end
  end

  assign view.level = level;
  assign view.state = state;
  assign view.clap  = clap;

endmodule

// File: src/csd_bright.sv
module csd_bright (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 square,
  input  logic                 emit,
  input  csd_pkg::light_view_t view,
  input  logic                 out_ready,
  output logic                 out_valid,
  output csd_pkg::out_word_t   out_data,
  output logic                 out_busy
);
  import csd_pkg::*;

  logic [19:0] prod;
  logic [13:0] y;
  logic [2:0]  n;
  logic [13:0] y_norm;

  assign y        = prod[19:6];
  assign out_busy = out_valid && !out_ready;
  assign y_norm   = y >> n;

  always_comb begin
    if (y[13]) n = 3'd6;
    else if (y[12]) n = 3'd5;
    else if (y[11]) n = 3'd4;
    else if (y[10]) n = 3'd3;
    else if (y[9]) n = 3'd2;
    else if (y[8]) n = 3'd1;
    else n = 3'd0;
  end

  always_ff @(posedge clk) begin
    if (square) prod <= view.level * view.level;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.light_level    <= view.level;
      out_data.prescale_shift <= SHIFT_TOP - n;
      out_data.duty           <= y_norm[7:0];
      out_data.clap_detected  <= view.clap;
      out_data.light_state    <= view.state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: src/clap_switch_dimmer_controller.sv
// One word per 1 ms tick goes in and exactly one result word comes out. A word is taken
// only while the block is idle; its result is produced by the scan of the sample ring,
// which reads one stored sample per cycle to find its peak-to-peak amplitude, followed by
// the controller update, the squaring multiply and the brightness normalization. The
// block is idle again once the result enters the output register, so a held result adds
// delay only if it is still waiting when the next result is done. Configuration writes
// are accepted in every cycle and take effect at once.
module clap_switch_dimmer_controller #(
  parameter int WINDOW_LENGTH = 10,
  parameter int RAMP_STEP     = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  csd_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output csd_pkg::out_word_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [csd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import csd_pkg::*;

  cfg_t        cfg;
  seq_cmd_t    cmd;
  seq_status_t status;
  light_view_t view;
  logic [10:0] amp;
  logic        scan_last;
  logic        out_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_threshold     <= ON_THRESHOLD_RESET;
      cfg.off_threshold    <= OFF_THRESHOLD_RESET;
      cfg.min_clap_ticks   <= MIN_CLAP_RESET;
      cfg.max_clap_ticks   <= MAX_CLAP_RESET;
      cfg.flash_level      <= FLASH_LEVEL_RESET;
      cfg.flash_ticks      <= FLASH_TICKS_RESET;
      cfg.idle_ticks       <= IDLE_TICKS_RESET;
      cfg.noise_off_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ON_THRESHOLD:     cfg.on_threshold     <= cfg_data[10:0];
        REG_OFF_THRESHOLD:    cfg.off_threshold    <= cfg_data[10:0];
        REG_MIN_CLAP_TICKS:   cfg.min_clap_ticks   <= cfg_data[6:0];
        REG_MAX_CLAP_TICKS:   cfg.max_clap_ticks   <= cfg_data[9:0];
        REG_FLASH_LEVEL:      cfg.flash_level      <= cfg_data[9:0];
        REG_FLASH_TICKS:      cfg.flash_ticks      <= cfg_data[9:0];
        REG_IDLE_TICKS:       cfg.idle_ticks       <= cfg_data[31:0];
        REG_NOISE_OFF_ENABLE: cfg.noise_off_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign status.scan_last = scan_last;
  assign status.out_busy  = out_busy;

  csd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  csd_window #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.load),
    .scan      (cmd.scan),
    .sample    (in_data.audio_sample),
    .scan_last (scan_last),
    .amp       (amp)
  );

  csd_light #(
    .RAMP_STEP (RAMP_STEP)
  ) u_light (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.load),
    .update    (cmd.update),
    .pot_level (in_data.pot_level),
    .pot_moved (in_data.pot_moved),
    .amp       (amp),
    .cfg       (cfg),
    .view      (view)
  );

  csd_bright u_bright (
    .clk       (clk),
    .rst       (rst),
    .square    (cmd.square),
    .emit      (cmd.emit),
    .view      (view),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_busy  (out_busy)
  );

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second word was taken while one was still being processed.");

  a_dark_when_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.light_state == LS_OFF || out_data.light_state == LS_OFF_NOISE ||
      out_data.light_state == LS_OFF_WAIT))
    |-> (out_data.light_level == 10'd0 && out_data.duty == 8'd0))
    else $error("The light is lit in an off state.");

  a_duty_normalized: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.prescale_shift != SHIFT_TOP) |-> out_data.duty[7])
    else $error("A shifted duty lost its leading bit.");

endmodule
